>>> rtl/fsme_pkg.sv
package fsme_pkg;

	localparam int unsigned DEF_FACTORIES = 4;
	localparam int unsigned DEF_MACHINES  = 8;
	localparam int unsigned DEF_JOBS      = 32;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned FAC_W   = 2;
	localparam int unsigned MAC_W   = 3;
	localparam int unsigned JOB_W   = 5;
	localparam int unsigned VAL_W   = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COST_W  = 40;
	localparam int unsigned SUM_W   = 48;
	localparam int unsigned PROD_W  = 32;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned RT_W    = 16;
	localparam int unsigned NM_W    = 4;
	localparam int unsigned NF_W    = 3;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_TIME = 2'd0,
		OP_LOAD_COST = 2'd1,
		OP_APPEND    = 2'd2,
		OP_REPORT    = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_JOB     = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_PATH    = 2'd2
	} kind_t;

	localparam logic [1:0] REG_RELEASE  = 2'd0;
	localparam logic [1:0] REG_MACHINES = 2'd1;
	localparam logic [1:0] REG_FACTORIES = 2'd2;

	typedef struct packed {
		op_t               op;
		logic [FAC_W-1:0]  factory;
		logic [MAC_W-1:0]  machine;
		logic [JOB_W-1:0]  job;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		kind_t              kind;
		logic [TIME_W-1:0]  job_completion;
		logic [COST_W-1:0]  job_cost;
		logic [FAC_W-1:0]   key_factory;
		logic [JOB_W-1:0]   path_job;
		logic [MAC_W-1:0]   path_machine;
		logic               last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AP_RD,
		ST_AP_WAIT,
		ST_AP_CALC,
		ST_AP_OUT,
		ST_RP_SCAN,
		ST_RP_SUM,
		ST_PW_RD,
		ST_PW_WAIT,
		ST_PW_EMIT,
		ST_PW_NEXT
	} state_t;

endpackage

>>> rtl/flow_shop_makespan_evaluator_core.sv
// channel  | direction | handshake          | payload
// input    | in        | push / full        | op, factory, machine, job, value
// result   | out       | pop / empty        | kind, job_completion, job_cost, key_factory,
//          |           |                    | path_job, path_machine, last
// config   | in        | apb psel/penable   | release_time, machines_in_use, factories_in_use
// loads are handled in the idle state; an append steps through read, wait and calc for every
// machine slot of MAX_MACHINES, then out, the registered finish-store read feeding the recurrence.
// a report scans each factory in use, then sums, then walks the path back step by step.
// reset clears counts, unit costs and the cost sum; stores need no clearing.
// a 2-entry command queue and one result register let each side stall alone.
module flow_shop_makespan_evaluator_core import fsme_pkg::*; #(
	parameter int unsigned MAX_FACTORIES = DEF_FACTORIES,
	parameter int unsigned MAX_MACHINES  = DEF_MACHINES,
	parameter int unsigned MAX_JOBS      = DEF_JOBS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [OP_W-1:0]     op,
	input  logic [FAC_W-1:0]    factory,
	input  logic [MAC_W-1:0]    machine,
	input  logic [JOB_W-1:0]    job,
	input  logic [VAL_W-1:0]    value,
	output logic                empty,
	input  logic                pop,
	output logic [KIND_W-1:0]   kind,
	output logic [TIME_W-1:0]   job_completion,
	output logic [COST_W-1:0]   job_cost,
	output logic [FAC_W-1:0]    key_factory,
	output logic [JOB_W-1:0]    path_job,
	output logic [MAC_W-1:0]    path_machine,
	output logic                last,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	cmd_t             cmd, q_cmd;
	logic             q_valid, q_take, res_valid;
	res_t             res;
	logic [RT_W-1:0]  rt_q;
	logic [NM_W-1:0]  nm_q;
	logic [NF_W-1:0]  nf_q;

	assign cmd = '{op: op_t'(op), factory: factory, machine: machine, job: job, value: value};
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q <= '0;
			nm_q <= 4'd8;
			nf_q <= 3'd4;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_RELEASE:   rt_q <= pwdata[RT_W-1:0];
				REG_MACHINES:  nm_q <= pwdata[NM_W-1:0];
				REG_FACTORIES: nf_q <= pwdata[NF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RELEASE:   prdata = 32'(rt_q);
			REG_MACHINES:  prdata = 32'(nm_q);
			REG_FACTORIES: prdata = 32'(nf_q);
			default:       prdata = '0;
		endcase
	end

	fsme_front #(.MAX_FACTORIES(MAX_FACTORIES), .MAX_MACHINES(MAX_MACHINES),
		.MAX_JOBS(MAX_JOBS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.q_cmd(q_cmd), .q_valid(q_valid), .q_take(q_take));

	fsme_back #(.MAX_FACTORIES(MAX_FACTORIES), .MAX_MACHINES(MAX_MACHINES),
		.MAX_JOBS(MAX_JOBS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_cmd(q_cmd), .q_valid(q_valid), .q_take(q_take),
		.release_time(rt_q), .machines_in_use(nm_q), .factories_in_use(nf_q),
		.res(res), .res_valid(res_valid), .res_room(pop));

	assign empty          = !res_valid;
	assign kind           = res.kind;
	assign job_completion = res.job_completion;
	assign job_cost       = res.job_cost;
	assign key_factory    = res.key_factory;
	assign path_job       = res.path_job;
	assign path_machine   = res.path_machine;
	assign last           = res.last;
endmodule

>>> rtl/fsme_ram.sv
module fsme_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/fsme_front.sv
module fsme_front import fsme_pkg::*; #(
	parameter int unsigned MAX_FACTORIES = DEF_FACTORIES,
	parameter int unsigned MAX_MACHINES  = DEF_MACHINES,
	parameter int unsigned MAX_JOBS      = DEF_JOBS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  cmd_t  cmd,
	output cmd_t  q_cmd,
	output logic  q_valid,
	input  logic  q_take
);
	localparam int unsigned QD = 2;
	cmd_t       buf_q [QD];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       acc, keep;

	// drop commands with out-of-range indexes here
	always_comb begin
		keep = 1'b1;
		case (cmd.op)
			OP_LOAD_TIME: keep = (32'(cmd.factory) < MAX_FACTORIES)
				&& (32'(cmd.machine) < MAX_MACHINES) && (32'(cmd.job) < MAX_JOBS);
			OP_LOAD_COST: keep = 32'(cmd.machine) < MAX_MACHINES;
			OP_APPEND:    keep = (32'(cmd.factory) < MAX_FACTORIES)
				&& (32'(cmd.job) < MAX_JOBS);
			default:      keep = 1'b1;
		endcase
	end

	assign full    = (cnt_q == 2'(QD));
	assign acc     = push && !full && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q[wp_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) wp_q <= ~wp_q;
			if (q_take && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(q_take && q_valid);
		end
	end
endmodule

>>> rtl/fsme_back.sv
module fsme_back import fsme_pkg::*; #(
	parameter int unsigned MAX_FACTORIES = DEF_FACTORIES,
	parameter int unsigned MAX_MACHINES  = DEF_MACHINES,
	parameter int unsigned MAX_JOBS      = DEF_JOBS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             q_cmd,
	input  logic             q_valid,
	output logic             q_take,
	input  logic [RT_W-1:0]  release_time,
	input  logic [NM_W-1:0]  machines_in_use,
	input  logic [NF_W-1:0]  factories_in_use,
	output res_t             res,
	output logic             res_valid,
	input  logic             res_room
);
	localparam int unsigned FW  = (MAX_FACTORIES > 1) ? $clog2(MAX_FACTORIES) : 1;
	localparam int unsigned MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
	localparam int unsigned PW  = $clog2(MAX_JOBS + 1);
	localparam int unsigned PT_D = MAX_FACTORIES * MAX_MACHINES * MAX_JOBS;
	localparam int unsigned PT_W = $clog2(PT_D);
	localparam int unsigned SQ_D = MAX_FACTORIES * MAX_JOBS;
	localparam int unsigned SQ_W = $clog2(SQ_D);
	localparam int unsigned MCW  = $clog2(MAX_MACHINES + 1);

	state_t state_q, state_d;

	logic [PW-1:0]      pcnt_q [MAX_FACTORIES];
	logic [VAL_W-1:0]   ucost_q [MAX_MACHINES];
	logic [SUM_W-1:0]   csum_q;
	logic [MCW-1:0]     nm;
	logic [3:0]         nf;

	// append state
	logic [FW-1:0]      f_q;
	logic [JOB_W-1:0]   job_q;
	logic [PW-1:0]      pos_q;
	logic [MW-1:0]      m_q;
	logic [TIME_W-1:0]  prev_m_q;     // finish on previous machine, this job
	logic [TIME_W-1:0]  last_fin_q;
	logic [COST_W-1:0]  cost_q;
	logic [PROD_W-1:0]  prod_s1;

	// report state
	logic [3:0]         sf_q;
	logic               found_q;
	logic [FW-1:0]      key_q;
	logic [TIME_W-1:0]  best_q;
	logic [MW-1:0]      wm_q;
	logic [PW-1:0]      wp_q;
	logic [TIME_W-1:0]  left_q;

	res_t               res_q;
	logic               res_v_q;
	logic               can_emit;

	// memories
	logic               pt_we, fs_we, sq_we;
	logic [PT_W-1:0]    pt_waddr, pt_raddr, fs_waddr, fs_raddr_a, fs_raddr_b;
	logic [VAL_W-1:0]   pt_rdata;
	logic [TIME_W:0]    fs_wdata, fs_rdata_a, fs_rdata_b;
	logic [SQ_W-1:0]    sq_waddr, sq_raddr;
	logic [JOB_W-1:0]   sq_rdata;

	function automatic logic [PT_W-1:0] addr(input logic [FW-1:0] f,
		input logic [MW-1:0] m, input logic [PW-1:0] p);
		logic [31:0] a;
		a = (32'(f) * MAX_MACHINES + 32'(m)) * MAX_JOBS + 32'(p);
		return a[PT_W-1:0];
	endfunction

	assign nm = (machines_in_use == '0) ? MCW'(1)
		: (32'(machines_in_use) > MAX_MACHINES) ? MCW'(MAX_MACHINES) : MCW'(machines_in_use);
	assign nf = (factories_in_use == '0) ? 4'd1
		: (32'(factories_in_use) > MAX_FACTORIES) ? 4'(MAX_FACTORIES) : 4'(factories_in_use);

	assign can_emit = !res_v_q || res_room;

	fsme_ram #(.WIDTH(VAL_W), .DEPTH(PT_D)) u_pt (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(q_cmd.value),
		.raddr(pt_raddr), .rdata(pt_rdata));
	fsme_ram #(.WIDTH(TIME_W+1), .DEPTH(PT_D)) u_fs_a (
		.clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr_a), .rdata(fs_rdata_a));
	fsme_ram #(.WIDTH(TIME_W+1), .DEPTH(PT_D)) u_fs_b (
		.clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr_b), .rdata(fs_rdata_b));
	fsme_ram #(.WIDTH(JOB_W), .DEPTH(SQ_D)) u_sq (
		.clk(clk), .we(sq_we), .waddr(sq_waddr), .wdata(job_q),
		.raddr(sq_raddr), .rdata(sq_rdata));

	// append datapath
	logic [TIME_W-1:0] start_c, upper_c, fin_c;
	logic [VAL_W-1:0]  p_c;
	logic              zero_c;
	logic [FW-1:0]     qf;
	assign qf = FW'(q_cmd.factory);
	always_comb begin
		p_c = (MCW'(m_q) < nm) ? pt_rdata : '0;
		upper_c = fs_rdata_b[TIME_W-1:0];
		if (m_q == '0) begin
			start_c = (pos_q == '0) ? TIME_W'(release_time) : upper_c;
		end else begin
			start_c = prev_m_q;
			if (pos_q != '0 && upper_c > prev_m_q) start_c = upper_c;
		end
		zero_c = (start_c == '0) || (m_q == '0 && pos_q == '0);
		fin_c  = start_c + TIME_W'(p_c);
	end

	// path walk step decision
	logic [TIME_W-1:0] w_fin, w_up;
	logic              w_stop;
	assign w_fin  = fs_rdata_a[TIME_W-1:0];
	assign w_up   = fs_rdata_b[TIME_W-1:0];
	assign w_stop = fs_rdata_a[TIME_W] || (wm_q == '0 && wp_q == '0);

	logic              last_m;
	assign last_m = (MCW'(m_q) == MCW'(MAX_MACHINES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_APPEND: if (pcnt_q[qf] != PW'(MAX_JOBS)) state_d = ST_AP_RD;
						OP_REPORT: state_d = ST_RP_SCAN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_AP_RD:   state_d = ST_AP_WAIT;
			ST_AP_WAIT: state_d = ST_AP_CALC;
			ST_AP_CALC: state_d = last_m ? ST_AP_OUT : ST_AP_RD;
			ST_AP_OUT:  if (can_emit) state_d = ST_IDLE;
			ST_RP_SCAN: if (sf_q == nf) state_d = ST_RP_SUM;
			ST_RP_SUM:  if (can_emit) state_d = found_q ? ST_PW_RD : ST_IDLE;
			ST_PW_RD:   state_d = ST_PW_WAIT;
			ST_PW_WAIT: state_d = ST_PW_EMIT;
			ST_PW_EMIT: if (can_emit) state_d = w_stop ? ST_IDLE : ST_PW_NEXT;
			ST_PW_NEXT: state_d = ST_PW_WAIT;
			default:    state_d = ST_IDLE;
		endcase
	end

	// scan reads finish of a factory's last job; the reads are pipelined, with the read
	// address register sf_rd_q running ahead of the compare in RP_SCAN
	logic [3:0]  sf_rd_q;
	logic        scan_v_q;
	logic [FW-1:0] scan_f_q;

	always_comb begin
		pt_we     = (state_q == ST_IDLE) && q_valid && (q_cmd.op == OP_LOAD_TIME);
		pt_waddr  = addr(qf, MW'(q_cmd.machine), PW'(q_cmd.job));
		pt_raddr  = addr(f_q, m_q, PW'(job_q));
		fs_we     = (state_q == ST_AP_CALC);
		fs_waddr  = addr(f_q, m_q, pos_q);
		fs_wdata  = {zero_c, fin_c};
		// walk: previous job on this machine first, then this job on the machine above
		if (state_q inside {ST_PW_RD, ST_PW_NEXT}) begin
			fs_raddr_b = addr(key_q, wm_q, wp_q - PW'(1));
		end else if (state_q inside {ST_PW_WAIT, ST_PW_EMIT}) begin
			fs_raddr_b = addr(key_q, wm_q - MW'(1), wp_q);
		end else begin
			fs_raddr_b = addr(f_q, m_q, pos_q - PW'(1));
		end
		fs_raddr_a = addr(key_q, wm_q, wp_q);
		if (state_q == ST_RP_SCAN) begin
			fs_raddr_a = addr(FW'(sf_rd_q), MW'(nm - MCW'(1)),
				pcnt_q[FW'(sf_rd_q)] - PW'(1));
		end
		sq_we     = (state_q == ST_AP_OUT) && can_emit;
		sq_waddr  = SQ_W'(32'(f_q) * MAX_JOBS + 32'(pos_q));
		sq_raddr  = SQ_W'(32'(key_q) * MAX_JOBS + 32'(wp_q));
		q_take    = (state_q == ST_IDLE) && q_valid
			&& !(q_cmd.op == OP_APPEND && pcnt_q[qf] != PW'(MAX_JOBS))
			&& (q_cmd.op != OP_REPORT);
		if ((state_q == ST_AP_OUT || state_q == ST_RP_SUM) && state_d == ST_IDLE) q_take = 1'b1;
		if (state_q == ST_PW_EMIT && state_d == ST_IDLE) q_take = 1'b1;
	end

	// product is formed while the read data waits, added in the calc cycle
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(ucost_q[m_q]) * PROD_W'(p_c);
	end

	logic res_set;
	assign res_set = (state_q inside {ST_AP_OUT, ST_RP_SUM, ST_PW_EMIT}) && can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_v_q <= 1'b0;
			csum_q  <= '0;
			for (int i = 0; i < MAX_FACTORIES; i++) pcnt_q[i] <= '0;
			for (int i = 0; i < MAX_MACHINES; i++) ucost_q[i] <= '0;
		end else begin
			state_q <= state_d;
			res_v_q <= res_set || (res_v_q && !res_room);
			if (state_q == ST_IDLE && q_valid && q_cmd.op == OP_LOAD_COST) begin
				ucost_q[MW'(q_cmd.machine)] <= q_cmd.value;
			end
			if (state_q == ST_AP_OUT && state_d == ST_IDLE) begin
				pcnt_q[f_q] <= pos_q + PW'(1);
				csum_q <= csum_q + SUM_W'(cost_q);
			end
			if (state_q == ST_RP_SUM && state_d != ST_RP_SUM) begin
				csum_q <= '0;
				for (int i = 0; i < MAX_FACTORIES; i++) pcnt_q[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				f_q    <= qf;
				job_q  <= q_cmd.job;
				pos_q  <= pcnt_q[qf];
				m_q    <= '0;
				cost_q <= '0;
				sf_q   <= '0;
				sf_rd_q <= '0;
				scan_v_q <= 1'b0;
				found_q <= 1'b0;
				key_q  <= '0;
				best_q <= '0;
			end
			ST_AP_CALC: begin
				prev_m_q <= fin_c;
				cost_q   <= cost_q + COST_W'(prod_s1);
				if (MCW'(m_q) == nm - MCW'(1)) last_fin_q <= fin_c;
				if (!last_m) m_q <= m_q + MW'(1);
			end
			ST_AP_OUT: begin
				if (can_emit) begin
					res_q.kind           <= KIND_JOB;
					res_q.job_completion <= last_fin_q;
					res_q.job_cost       <= cost_q;
					res_q.key_factory    <= FAC_W'(f_q);
					res_q.path_job       <= job_q;
					res_q.path_machine   <= '0;
					res_q.last           <= 1'b0;
				end
			end
			ST_RP_SCAN: begin
				if (sf_rd_q != nf) sf_rd_q <= sf_rd_q + 4'd1;
				scan_v_q <= (sf_rd_q != nf) && (pcnt_q[FW'(sf_rd_q)] != '0);
				scan_f_q <= FW'(sf_rd_q);
				if (sf_rd_q != '0) sf_q <= sf_q + 4'd1;
				if (scan_v_q && (!found_q || w_fin > best_q)) begin
					best_q  <= w_fin;
					key_q   <= scan_f_q;
					found_q <= 1'b1;
				end
			end
			ST_RP_SUM: begin
				if (can_emit) begin
					res_q.kind           <= KIND_SUMMARY;
					res_q.job_completion <= best_q;
					res_q.job_cost       <= (csum_q > SUM_W'({COST_W{1'b1}}))
						? {COST_W{1'b1}} : csum_q[COST_W-1:0];
					res_q.key_factory    <= FAC_W'(key_q);
					res_q.path_job       <= '0;
					res_q.path_machine   <= '0;
					res_q.last           <= !found_q;
					wm_q <= MW'(nm - MCW'(1));
					wp_q <= pcnt_q[key_q] - PW'(1);
				end
			end
			ST_PW_WAIT: begin
				left_q <= fs_rdata_b[TIME_W-1:0];
			end
			ST_PW_EMIT: begin
				if (can_emit) begin
					res_q.kind           <= KIND_PATH;
					res_q.job_completion <= w_fin;
					res_q.job_cost       <= '0;
					res_q.key_factory    <= FAC_W'(key_q);
					res_q.path_job       <= sq_rdata;
					res_q.path_machine   <= MAC_W'(wm_q);
					res_q.last           <= w_stop;
					// go left unless the machine above finished strictly later or this is the first job
					if (!w_stop) begin
						if (wm_q != '0) begin
							if (wp_q != '0 && !(w_up > left_q)) wp_q <= wp_q - PW'(1);
							else wm_q <= wm_q - MW'(1);
						end else begin
							wp_q <= wp_q - PW'(1);
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb res = res_q;
	assign res_valid = res_v_q;
endmodule

>>> dv/flow_shop_makespan_checker.sv
`timescale 1ns / 1ps
module flow_shop_makespan_checker import fsme_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [OP_W-1:0]   op,
	input  logic [FAC_W-1:0]  factory,
	input  logic [MAC_W-1:0]  machine,
	input  logic [JOB_W-1:0]  job,
	input  logic [VAL_W-1:0]  value,
	input  logic              empty,
	input  logic              pop,
	input  logic [KIND_W-1:0] kind,
	input  logic [TIME_W-1:0] job_completion,
	input  logic [COST_W-1:0] job_cost,
	input  logic [FAC_W-1:0]  key_factory,
	input  logic [JOB_W-1:0]  path_job,
	input  logic [MAC_W-1:0]  path_machine,
	input  logic              last,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output int unsigned       fail_count,
	output int unsigned       waiting
);

	localparam logic [COST_W-1:0] COST_CAP = '1;

	logic [VAL_W-1:0]  proc_q [DEF_FACTORIES][DEF_MACHINES][DEF_JOBS];
	logic [VAL_W-1:0]  rate_q [DEF_MACHINES];
	logic [TIME_W-1:0] done_at [DEF_FACTORIES][DEF_MACHINES][DEF_JOBS];
	bit                from_zero [DEF_FACTORIES][DEF_MACHINES][DEF_JOBS];
	logic [JOB_W-1:0]  order_q [DEF_FACTORIES][DEF_JOBS];
	int unsigned       seq_len [DEF_FACTORIES];
	logic [SUM_W-1:0]  cost_acc;
	logic [RT_W-1:0]   release_q;
	logic [NM_W-1:0]   machines_q;
	logic [NF_W-1:0]   factories_q;
	res_t              due_q [$];

	function automatic int unsigned machines_eff();
		if (machines_q == 0) return 1;
		return machines_q > DEF_MACHINES ? DEF_MACHINES : machines_q;
	endfunction

	function automatic int unsigned factories_eff();
		if (factories_q == 0) return 1;
		return factories_q > DEF_FACTORIES ? DEF_FACTORIES : factories_q;
	endfunction

	function automatic res_t make_res(kind_t k, logic [TIME_W-1:0] t, logic [COST_W-1:0] c,
			int unsigned f, logic [JOB_W-1:0] j, int unsigned m, bit l);
		res_t r;
		r.kind = k;
		r.job_completion = t;
		r.job_cost = c;
		r.key_factory = f[FAC_W-1:0];
		r.path_job = j;
		r.path_machine = m[MAC_W-1:0];
		r.last = l;
		return r;
	endfunction

	task automatic expect_res(res_t r);
		due_q.insert(due_q.size(), r);
	endtask

	task automatic schedule_job(int unsigned f, logic [JOB_W-1:0] j);
		int unsigned pos;
		int unsigned nm;
		longint unsigned cost;
		logic [TIME_W-1:0] start;
		logic [VAL_W-1:0] p;
		pos = seq_len[f];
		nm = machines_eff();
		cost = 0;
		if (pos >= DEF_JOBS) return;
		for (int m = 0; m < DEF_MACHINES; m++) begin
			p = (m < nm) ? proc_q[f][m][j] : '0;
			if (m == 0) begin
				start = (pos == 0) ? TIME_W'(release_q) : done_at[f][0][pos-1];
			end else begin
				start = done_at[f][m-1][pos];
				if (pos != 0 && done_at[f][m][pos-1] > start)
					start = done_at[f][m][pos-1];
			end
			from_zero[f][m][pos] = (start == 0) || (m == 0 && pos == 0);
			done_at[f][m][pos] = start + p;
			if (m < nm) cost += longint'(rate_q[m]) * p;
		end
		order_q[f][pos] = j;
		seq_len[f] = pos + 1;
		cost_acc = cost_acc + SUM_W'(cost);
		expect_res(make_res(KIND_JOB, done_at[f][nm-1][pos], COST_W'(cost), f, j, 0, 0));
	endtask

	task automatic report_schedule();
		int unsigned nm;
		int unsigned key;
		int unsigned pos;
		int unsigned m;
		logic [TIME_W-1:0] best;
		logic [TIME_W-1:0] v;
		bit found;
		bit stop;
		nm = machines_eff();
		key = 0;
		best = 0;
		found = 0;
		for (int f = 0; f < factories_eff(); f++) begin
			if (seq_len[f] != 0) begin
				v = done_at[f][nm-1][seq_len[f]-1];
				if (!found || v > best) begin
					best = v;
					key = f;
					found = 1;
				end
			end
		end
		expect_res(make_res(KIND_SUMMARY, best,
			(cost_acc > SUM_W'(COST_CAP)) ? COST_CAP : cost_acc[COST_W-1:0], key, 0, 0, !found));
		if (found) begin
			pos = seq_len[key] - 1;
			m = nm - 1;
			// walk back from the makespan job toward a zero start
			while (1) begin
				stop = from_zero[key][m][pos] || (m == 0 && pos == 0);
				expect_res(make_res(KIND_PATH, done_at[key][m][pos], 0, key,
					order_q[key][pos], m, stop));
				if (stop) break;
				if (m != 0) begin
					if (pos != 0 && !(done_at[key][m-1][pos] > done_at[key][m][pos-1]))
						pos--;
					else
						m--;
				end else begin
					pos--;
				end
			end
		end
		foreach (seq_len[f]) seq_len[f] = 0;
		cost_acc = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			release_q = 0;
			machines_q = DEF_MACHINES;
			factories_q = DEF_FACTORIES;
			foreach (rate_q[m]) rate_q[m] = 0;
			foreach (seq_len[f]) seq_len[f] = 0;
			cost_acc = 0;
			fail_count = 0;
			due_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RELEASE:   release_q = pwdata[RT_W-1:0];
					REG_MACHINES:  machines_q = pwdata[NM_W-1:0];
					REG_FACTORIES: factories_q = pwdata[NF_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				got.kind = kind_t'(kind);
				got.job_completion = job_completion;
				got.job_cost = job_cost;
				got.key_factory = key_factory;
				got.path_job = path_job;
				got.path_machine = path_machine;
				got.last = last;
				if (due_q.size() == 0) begin
					$display("%0t unexpected result transfer: kind=%0d comp=%0d cost=%0d",
						$time, kind, job_completion, job_cost);
					fail_count++;
				end else begin
					want = due_q.pop_front();
					if (got !== want) begin
						$display("%0t expected k=%0d t=%0d c=%0d f=%0d j=%0d m=%0d l=%0d",
							$time, want.kind, want.job_completion, want.job_cost,
							want.key_factory, want.path_job, want.path_machine, want.last);
						$display("%0t actual   k=%0d t=%0d c=%0d f=%0d j=%0d m=%0d l=%0d",
							$time, got.kind, got.job_completion, got.job_cost,
							got.key_factory, got.path_job, got.path_machine, got.last);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				case (op_t'(op))
					OP_LOAD_TIME: proc_q[factory][machine][job] = value;
					OP_LOAD_COST: rate_q[machine] = value;
					OP_APPEND:    schedule_job(factory, job);
					OP_REPORT:    report_schedule();
					default: ;
				endcase
			end
		end
		waiting = due_q.size();
	end

endmodule

>>> dv/flow_shop_makespan_evaluator_core_tb.sv
`timescale 1ns / 1ps
module flow_shop_makespan_evaluator_core_tb;
	import fsme_pkg::*;

	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned SETTLE = 200;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [OP_W-1:0]   op;
	logic [FAC_W-1:0]  factory;
	logic [MAC_W-1:0]  machine;
	logic [JOB_W-1:0]  job;
	logic [VAL_W-1:0]  value;
	logic              empty;
	logic              pop;
	logic [KIND_W-1:0] kind;
	logic [TIME_W-1:0] job_completion;
	logic [COST_W-1:0] job_cost;
	logic [FAC_W-1:0]  key_factory;
	logic [JOB_W-1:0]  path_job;
	logic [MAC_W-1:0]  path_machine;
	logic              last;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [3:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int unsigned       fail_count;
	int unsigned       waiting;

	bit          loaded [DEF_FACTORIES][DEF_MACHINES][DEF_JOBS];
	bit          no_gaps;
	int unsigned pops_seen;
	int unsigned quiet_cycles;

	flow_shop_makespan_evaluator_core u_top (.*);

	flow_shop_makespan_checker u_chk (.*);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [VAL_W-1:0] pick_time();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2) return 0;
		if (r == 2) return '1;
		if (r == 3) return $urandom_range(0, 65535);
		return $urandom_range(1, 20);
	endfunction

	function automatic logic [JOB_W-1:0] pick_job();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 8) return $urandom_range(0, 1);
		if (r == 8) return 31;
		return $urandom_range(0, 31);
	endfunction

	task automatic send_cmd(op_t o, int unsigned f, int unsigned m, int unsigned j,
			logic [VAL_W-1:0] v);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) push <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1;
		op <= o;
		factory <= f;
		machine <= m;
		job <= j;
		value <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		if (o == OP_LOAD_TIME) loaded[f][m][j] = 1;
	endtask

	task automatic add_job(int unsigned f, int unsigned j, bit force_max);
		for (int m = 0; m < DEF_MACHINES; m++)
			if (!loaded[f][m][j] || force_max)
				send_cmd(OP_LOAD_TIME, f, m, j, force_max ? 16'hffff : pick_time());
		send_cmd(OP_APPEND, f, $urandom_range(0, 7), j, $urandom_range(0, 65535));
	endtask

	// let every expected result drain before touching the registers
	task automatic wait_drained();
		@(negedge clk) push <= 0;
		wait (waiting == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, int unsigned v);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk) penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic set_regs(int unsigned rt, int unsigned nm, int unsigned nf);
		wait_drained();
		reg_write(REG_RELEASE, rt);
		reg_write(REG_MACHINES, nm);
		reg_write(REG_FACTORIES, nf);
	endtask

	task automatic random_mix(int unsigned n);
		int unsigned r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				add_job($urandom_range(0, 3), pick_job(), 0);
			else if (r < 75)
				send_cmd(OP_LOAD_TIME, $urandom_range(0, 3), $urandom_range(0, 7),
					$urandom_range(0, 31), pick_time());
			else if (r < 87)
				send_cmd(OP_LOAD_COST, $urandom_range(0, 3), $urandom_range(0, 7),
					$urandom_range(0, 31), ($urandom_range(0, 4) == 0) ? 16'hffff
					: $urandom_range(0, 9));
			else
				send_cmd(OP_REPORT, $urandom_range(0, 3), $urandom_range(0, 7),
					$urandom_range(0, 31), $urandom_range(0, 65535));
		end
		send_cmd(OP_REPORT, 0, 0, 0, 0);
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		push = 0;
		op = OP_LOAD_TIME;
		factory = 0;
		machine = 0;
		job = 0;
		value = 0;
		pop = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		no_gaps = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1;

		// directed: empty report, cost extremes, first job at release zero
		send_cmd(OP_REPORT, 0, 0, 0, 0);
		send_cmd(OP_LOAD_COST, 0, 0, 0, 16'hffff);
		send_cmd(OP_LOAD_COST, 0, 7, 0, 0);
		send_cmd(OP_LOAD_COST, 3, 3, 31, 3);
		add_job(0, 0, 0);
		add_job(3, 31, 0);
		send_cmd(OP_APPEND, 0, 0, 0, 0);
		send_cmd(OP_REPORT, 3, 7, 31, 16'hffff);

		set_regs(65535, 15, 7);
		random_mix(10);
		set_regs(0, 1, 1);
		random_mix(10);
		set_regs(0, 0, 0);
		random_mix(8);
		no_gaps = 1;
		set_regs(7, 8, 4);
		random_mix(12);
		no_gaps = 0;
		for (int k = 0; k < 3; k++) begin
			set_regs($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : 0,
				$urandom_range(1, 8), $urandom_range(1, 4));
			random_mix(8);
		end

		// fill one factory past its capacity with maximal cost to saturate the sum
		set_regs(65535, 8, 4);
		for (int m = 0; m < DEF_MACHINES; m++)
			send_cmd(OP_LOAD_COST, 0, m, 0, 16'hffff);
		add_job(0, 0, 1);
		add_job(0, 1, 1);
		for (int k = 2; k < 34; k++)
			send_cmd(OP_APPEND, 0, 0, k % 2, 0);
		add_job(1, 0, 1);
		send_cmd(OP_REPORT, 0, 0, 0, 0);

		wait_drained();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side: random stalls plus one long hold-off to back up the input
	initial begin
		int unsigned hold;
		bit long_done;
		hold = 0;
		long_done = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pop <= 0;
				hold--;
			end else if (!long_done && pops_seen >= 50) begin
				long_done = 1;
				hold = 400;
				pop <= 0;
			end else if ($urandom_range(0, 99) < 3) begin
				hold = $urandom_range(5, 40);
				pop <= 0;
			end else begin
				pop <= no_gaps || ($urandom_range(0, 99) < 70);
			end
		end
	end

	always @(posedge clk) begin
		if (pop && !empty) pops_seen <= pops_seen + 1;
		if ((pop && !empty) || (push && !full))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		pops_seen = 0;
		quiet_cycles = 0;
	end

endmodule

>>> flow_shop_makespan_evaluator_core.f
rtl/fsme_pkg.sv
rtl/fsme_ram.sv
rtl/fsme_front.sv
rtl/fsme_back.sv
rtl/flow_shop_makespan_evaluator_core.sv
dv/flow_shop_makespan_checker.sv
dv/flow_shop_makespan_evaluator_core_tb.sv
